[design/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and codes of the first-fit block allocator: request and
// response payloads, block table entry layout and status codes
// ----------------------------------------------------------------------------
package ffba_pkg;

   // request modes
   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NULL     = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;
   localparam logic [1:0] ST_UNKNOWN  = 2'd3;

   // 16-bit address space, heap top may reach its full size
   localparam int ADDR_SPACE = 65536;
   localparam logic [16:0] LIMIT_RESET = 17'h10000;

   typedef struct packed {
      logic        mode;
      logic [15:0] request_bytes;
      logic [15:0] release_address;
   } req_type;

   typedef struct packed {
      logic [15:0] data_address;
      logic [1:0]  status;
   } rsp_type;

   // one row of the block table
   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
      logic        free;
   } entry_type;

endpackage

[design/ffba_table.sv]
// ----------------------------------------------------------------------------
// ffba_table
// block table storage: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ffba_table #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // synchronous write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/first_fit_block_allocator_core.sv]
// flow: a null request, or a release to an empty table, goes straight to the
//   response; an allocate to an empty table goes to the append step; otherwise the
//   walk reads entries in order up to a hit, and an allocate that walks all entries (at most MAX_BLOCKS) then appends
// throughput: one request at a time, next accept in the cycle after the response is
//   loaded, delayed while a stalled response holds the output register
// reset: synchronous; clears block count, heap top and handshakes, heap_limit 65536
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// first-fit allocator over a byte heap: allocate scans the block table for the
// first free block large enough, else appends at the heap top; release frees a
// block or pops it when it ends at the heap top
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int HEAP_BYTES   = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ffba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ffba_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [16:0]      csr_wr_data
);
   import ffba_pkg::*;

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int ENTRY_W = $bits(entry_type);
   localparam int CAP_I   = (HEAP_BYTES < ADDR_SPACE) ? HEAP_BYTES : ADDR_SPACE;
   localparam logic [16:0] LIMIT_CAP = 17'(CAP_I);
   localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
   localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);
   localparam logic [17:0] HDR18 = 18'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_BLOCKS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_APPEND = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]       state_ff, state_in;
   req_type          op_ff, op_in;
   rsp_type          res_ff, res_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [16:0]      top_ff, top_in;
   logic [16:0]      limit_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type        rd_entry;

   logic [16:0]      eff_limit;
   logic [17:0]      append_end;
   logic             alloc_hit;
   logic             release_hit;
   logic             release_top;
   logic             scan_last;
   logic             out_free;
   logic             is_null;

   // block table
   ffba_table #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   // effective limit and append end
   assign eff_limit  = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;
   assign append_end = {1'b0, top_ff} + HDR18 + {2'b00, op_ff.request_bytes};

   // entry compare on the word read this cycle
   assign alloc_hit   = rd_entry.free && (rd_entry.length >= op_ff.request_bytes);
   assign release_hit = ({1'b0, rd_entry.start} + HDR17) == {1'b0, op_ff.release_address};
   assign release_top = ({1'b0, op_ff.release_address} + {1'b0, rd_entry.length}) == top_ff;
   assign scan_last   = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   assign is_null = (req_data.mode == MODE_ALLOC) ? (req_data.request_bytes == 16'd0)
                                                  : (req_data.release_address == 16'd0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // sequencer: the table is written only in the last work cycle of a request,
   // and the next read is issued no earlier than the next accept
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      res_in   = res_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      top_in   = top_ff;
      rd_addr  = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_entry = rd_entry;
      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_valid) begin
               op_in  = req_data;
               idx_in = '0;
               res_in.data_address = 16'd0;
               res_in.status       = ST_OK;
               if (is_null) begin
                  res_in.status = ST_NULL;
                  state_in      = S_DONE;
               end else if (count_ff == '0) begin
                  if (req_data.mode == MODE_ALLOC) begin
                     state_in = S_APPEND;
                  end else begin
                     res_in.status = ST_UNKNOWN;
                     state_in      = S_DONE;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_addr = idx_ff + IDX_W'(1);
            if (op_ff.mode == MODE_ALLOC && alloc_hit) begin
               // reuse a free block, shrink it to the request
               wr_en           = 1'b1;
               wr_entry.length = op_ff.request_bytes;
               wr_entry.free   = 1'b0;
               res_in.data_address = rd_entry.start + HDR16;
               res_in.status       = ST_OK;
               state_in            = S_DONE;
            end else if (op_ff.mode == MODE_RELEASE && release_hit) begin
               if (release_top) begin
                  top_in   = {1'b0, rd_entry.start};
                  count_in = CNT_W'(idx_ff);
               end else begin
                  wr_en         = 1'b1;
                  wr_entry.free = 1'b1;
               end
               res_in.status = ST_OK;
               state_in      = S_DONE;
            end else if (scan_last) begin
               if (op_ff.mode == MODE_ALLOC) begin
                  state_in = S_APPEND;
               end else begin
                  res_in.status = ST_UNKNOWN;
                  state_in      = S_DONE;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_APPEND: begin
            if (count_ff == FULL_COUNT || append_end > {1'b0, eff_limit}) begin
               res_in.data_address = 16'd0;
               res_in.status       = ST_NO_SPACE;
            end else begin
               wr_en           = 1'b1;
               wr_addr         = count_ff[IDX_W-1:0];
               wr_entry.start  = top_ff[15:0];
               wr_entry.length = op_ff.request_bytes;
               wr_entry.free   = 1'b0;
               count_in        = count_ff + CNT_W'(1);
               top_in          = append_end[16:0];
               res_in.data_address = top_ff[15:0] + HDR16;
               res_in.status       = ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= 17'd0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      res_ff <= res_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/ffba_checker.sv]
// ----------------------------------------------------------------------------
// ffba_checker
// port-level checks of the allocator core, bound to the allocator core module
// ----------------------------------------------------------------------------
module ffba_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ffba_pkg::rsp_type rsp_data
);
   import ffba_pkg::*;

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // one request at a time: busy after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // only an OK response may carry an address
   a_addr_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.data_address == 16'd0)
      else $error("address returned with a failure status");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);

[verif/ffba_response_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_response_checker
// watches the request, response and csr ports of the block allocator, keeps a
// shadow block table of its own and compares every response with the one the
// shadow table predicts, oldest first
// ----------------------------------------------------------------------------
module ffba_response_checker #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int HEAP_BYTES   = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ffba_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ffba_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [16:0]       csr_wr_data,
   output int                mismatch_count,
   output int                outstanding
);
   import ffba_pkg::*;

   // shadow block table and heap state
   logic [15:0] shadow_start  [MAX_BLOCKS];
   logic [15:0] shadow_length [MAX_BLOCKS];
   logic        shadow_free   [MAX_BLOCKS];
   int unsigned shadow_count;
   logic [16:0] shadow_top;
   logic [16:0] shadow_limit;

   // responses the block still owes, oldest first
   rsp_type due_responses[$];

   // heap top may not pass the register, the heap size or the address space
   function automatic int unsigned usable_limit();
      int unsigned lim;
      lim = shadow_limit;
      if (lim > HEAP_BYTES) lim = HEAP_BYTES;
      if (lim > ADDR_SPACE) lim = ADDR_SPACE;
      return lim;
   endfunction

   function automatic rsp_type allocate_block(logic [15:0] bytes);
      rsp_type     resp;
      int unsigned heap_end;
      int unsigned idx;
      resp.data_address = '0;
      resp.status       = ST_OK;
      if (bytes == 0) begin
         resp.status = ST_NULL;
         return resp;
      end
      // first fit in address order, the reused block shrinks to the request
      for (idx = 0; idx < shadow_count; idx++) begin
         if (shadow_free[idx] && shadow_length[idx] >= bytes) begin
            shadow_free[idx]   = 1'b0;
            shadow_length[idx] = bytes;
            resp.data_address  = 16'(int'(shadow_start[idx]) + HEADER_BYTES);
            return resp;
         end
      end
      // otherwise append header plus request at the heap top
      heap_end = int'(shadow_top) + HEADER_BYTES + int'(bytes);
      if (shadow_count >= MAX_BLOCKS || heap_end > usable_limit()) begin
         resp.status = ST_NO_SPACE;
         return resp;
      end
      shadow_start[shadow_count]  = shadow_top[15:0];
      shadow_length[shadow_count] = bytes;
      shadow_free[shadow_count]   = 1'b0;
      shadow_count++;
      resp.data_address = 16'(int'(shadow_top) + HEADER_BYTES);
      shadow_top        = 17'(heap_end);
      return resp;
   endfunction

   function automatic rsp_type release_block(logic [15:0] addr);
      rsp_type     resp;
      int unsigned idx;
      resp.data_address = '0;
      resp.status       = ST_OK;
      if (addr == 0) begin
         resp.status = ST_NULL;
         return resp;
      end
      for (idx = 0; idx < shadow_count; idx++) begin
         if (int'(shadow_start[idx]) + HEADER_BYTES == int'(addr)) begin
            // a block ending at the heap top is popped, any other one is freed
            if (int'(addr) + int'(shadow_length[idx]) == int'(shadow_top)) begin
               shadow_top   = 17'(shadow_start[idx]);
               shadow_count = idx;
            end else begin
               shadow_free[idx] = 1'b1;
            end
            return resp;
         end
      end
      resp.status = ST_UNKNOWN;
      return resp;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_count = 0;
         shadow_top   = '0;
         shadow_limit = LIMIT_RESET;
         due_responses.delete();
      end else begin
         // compare the response taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               $error("response with none awaited: data_address %0d status %0d",
                      rsp_data.data_address, rsp_data.status);
               mismatch_count++;
            end else begin
               want = due_responses.pop_front();
               if (rsp_data.data_address !== want.data_address) begin
                  $error("data_address: expected %0d, actual %0d",
                         want.data_address, rsp_data.data_address);
                  mismatch_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  mismatch_count++;
               end
            end
         end
         // heap limit register write
         if (csr_wr_en) shadow_limit = csr_wr_data;
         // predict the request taken at this edge
         if (req_valid && req_ready) begin
            if (req_data.mode == MODE_ALLOC) begin
               due_responses.push_back(allocate_block(req_data.request_bytes));
            end else begin
               due_responses.push_back(release_block(req_data.release_address));
            end
         end
      end
      outstanding = due_responses.size();
   end

endmodule

[verif/tb_first_fit_block_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_core
// drives allocate and release requests into the first-fit allocator under
// several heap limits with random gaps and stalls on both channels; the
// response checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_core;
   import ffba_pkg::*;

   localparam int MAX_BLOCKS       = 64;
   localparam int HEADER_BYTES     = 16;
   localparam int HEAP_BYTES       = 65536;
   localparam int NUM_PHASES       = 7;
   localparam int RANDOM_PER_PHASE = 220;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int POOL_DEPTH       = 96;

   // heap limits per phase: above range, zero, small, exact full size
   localparam logic [16:0] PHASE_LIMITS [NUM_PHASES] = '{
      17'h1FFFF, 17'd0, 17'd1000, 17'd4096, 17'h10001, 17'd300, 17'h10000
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [16:0] csr_wr_data = '0;
   int          mismatch_count;
   int          outstanding;

   // data addresses handed out, used to aim releases at live blocks
   logic [15:0] live_addresses[$];
   bit          calm          = 1'b0;
   int          hold_requests = 0;

   always #5 clock = ~clock;

   first_fit_block_allocator_core #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES),
      .HEAP_BYTES   (HEAP_BYTES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ffba_response_checker #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES),
      .HEAP_BYTES   (HEAP_BYTES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // watchdog
   initial begin
      #(10_000_000);
      $display("Mismatches found");
      $finish;
   end

   // both handshake signals change only at rising edges, so the values seen
   // here are the ones the next edge takes
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_data.status == ST_OK &&
          rsp_data.data_address != 0) begin
         if (live_addresses.size() >= POOL_DEPTH) void'(live_addresses.pop_front());
         live_addresses.push_back(rsp_data.data_address);
      end
   end

   // response side: long hold on demand, random stall bursts, ready stretches
   initial begin
      int span;
      int holds_done;
      holds_done = 0;
      forever begin
         if (hold_requests > holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            span = calm ? 1 : $urandom_range(1, 40);
            repeat (span) @(posedge clock);
         end
      end
   end

   function automatic req_type make_request(logic mode, logic [15:0] bytes,
                                            logic [15:0] addr);
      req_type item;
      item.mode            = mode;
      item.request_bytes   = bytes;
      item.release_address = addr;
      return item;
   endfunction

   // mostly allocations and releases of live blocks, some null and stray ones
   function automatic req_type random_request(int unsigned size_cap);
      int unsigned pick;
      int unsigned slot;
      logic [15:0] bytes;
      logic [15:0] addr;
      pick  = $urandom_range(0, 99);
      bytes = 16'($urandom);
      addr  = 16'($urandom);
      if (pick < 45) begin
         case ($urandom_range(0, 19))
            0:       bytes = '0;
            1:       ;
            2:       bytes = 16'hFFFF;
            default: bytes = 16'($urandom_range(1, size_cap));
         endcase
         return make_request(MODE_ALLOC, bytes, addr);
      end
      if (pick < 88 && live_addresses.size() > 0) begin
         slot = $urandom_range(0, live_addresses.size() - 1);
         addr = live_addresses[slot];
         // some addresses stay in the pool so a block gets released twice
         if ($urandom_range(0, 3) != 0) live_addresses.delete(slot);
         return make_request(MODE_RELEASE, bytes, addr);
      end
      case ($urandom_range(0, 2))
         0:       addr = '0;
         1:       addr = (live_addresses.size() > 0) ? live_addresses[0] + 16'd1 : 16'hFFFF;
         default: ;
      endcase
      return make_request(MODE_RELEASE, bytes, addr);
   endfunction

   task automatic send_request(req_type item);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_limit(logic [16:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned size_cap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: null requests, stray releases, reuse, top pops, limit edge
      send_request(make_request(MODE_ALLOC, 16'd0, 16'd0));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'd0));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'hFFFF));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'd16));
      send_request(make_request(MODE_ALLOC, 16'd1, 16'd0));
      send_request(make_request(MODE_ALLOC, 16'hFFFF, 16'd0));
      send_request(make_request(MODE_ALLOC, 16'd100, 16'd0));
      send_request(make_request(MODE_ALLOC, 16'd200, 16'd0));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'd33));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'd33));
      send_request(make_request(MODE_ALLOC, 16'd50, 16'd0));
      send_request(make_request(MODE_ALLOC, 16'd60, 16'd0));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'd365));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'd365));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'd149));
      send_request(make_request(MODE_ALLOC, 16'h8000, 16'd0));
      send_request(make_request(MODE_ALLOC, 16'd32603, 16'd0));
      send_request(make_request(MODE_ALLOC, 16'd1, 16'd0));
      send_request(make_request(MODE_RELEASE, 16'd0, 16'd32933));
      send_request(make_request(MODE_RELEASE, 16'hFFFF, 16'd16));
      send_request(make_request(MODE_ALLOC, 16'd1, 16'hFFFF));

      // tiny blocks until the table reports full
      repeat (70) send_request(make_request(MODE_ALLOC, 16'($urandom_range(1, 8)),
                                            16'($urandom)));

      // random traffic under each heap limit, no idling in the last phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit(PHASE_LIMITS[p]);
         calm     = (p == NUM_PHASES - 1);
         size_cap = (PHASE_LIMITS[p] < 17'd5000) ? 40 : 500;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // long response hold while requests keep coming
            if (p == 1 && n == 40) hold_requests++;
            if (!calm && $urandom_range(0, 99) == 0) wait_for_drain();
            send_request(random_request((n % 16 == 0) ? 65535 : size_cap));
         end
      end

      wait_for_drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
